// ----- design/tkst_pkg.sv -----
`timescale 1ns / 1ps

package tkst_pkg;

    localparam int CAPACITY_DEF = 10;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        player_key;
        logic signed [31:0] score;
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic [31:0]        entry_key;
        logic signed [31:0] entry_score;
        logic               last;
    } t_result;

    // classified command as held in the queue; neither flag set means list
    typedef struct packed {
        logic               is_insert;
        logic               is_search;
        logic [31:0]        player_key;
        logic signed [31:0] score;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_out;

    typedef struct packed {
        logic scanning;
        logic count_ok;
    } t_status;

endpackage

// ----- design/tkst_front.sv -----
`timescale 1ns / 1ps

module tkst_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tkst_pkg::t_cmd       i_cmd,
    output tkst_pkg::t_queue_out o_queue,
    input  logic                 i_pop
);

    tkst_pkg::t_job r_q [2];
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           r_rd;
    logic           n_rd;
    logic           push;
    logic           pop;
    logic           wr;
    tkst_pkg::t_job job_in;

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy && (i_cmd.opcode != tkst_pkg::OP_NONE);
    assign pop  = i_pop && (r_cnt != 2'd0);
    assign wr   = r_rd ^ r_cnt[0];

    always_comb begin
        job_in.is_insert  = (i_cmd.opcode == tkst_pkg::OP_INSERT);
        job_in.is_search  = (i_cmd.opcode == tkst_pkg::OP_SEARCH);
        job_in.player_key = i_cmd.player_key;
        job_in.score      = i_cmd.score;
    end

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(pop);
        n_rd  = pop ? ~r_rd : r_rd;
    end

    assign o_queue.valid = (r_cnt != 2'd0);
    assign o_queue.job   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[wr] <= job_in;
        end
    end

endmodule

// ----- design/tkst_back.sv -----
`timescale 1ns / 1ps

module tkst_back #(
    parameter int CAPACITY = tkst_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = tkst_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tkst_pkg::t_queue_out i_queue,
    output logic                 o_pop,
    output logic                 o_valid,
    output tkst_pkg::t_result    o_result,
    output tkst_pkg::t_status    o_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic [KEY_BITS-1:0] r_key   [CAPACITY];
    logic signed [31:0]  r_score [CAPACITY];
    logic [KEY_BITS-1:0] n_key   [CAPACITY];
    logic signed [31:0]  n_score [CAPACITY];

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_state;
    logic                n_state;
    logic [IW-1:0]       r_step;
    logic [IW-1:0]       n_step;
    logic                r_search;
    logic                n_search;
    logic                r_hit;
    logic                n_hit;
    logic [KEY_BITS-1:0] r_tkey;
    logic [KEY_BITS-1:0] n_tkey;
    logic                r_valid;
    logic                n_valid;
    tkst_pkg::t_result   r_res;
    tkst_pkg::t_result   n_res;

    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] prev_ge;
    logic [KEY_BITS-1:0] job_key;
    logic [CW-1:0]       last_idx;
    logic                last_step;

    assign job_key   = KEY_BITS'(i_queue.job.player_key);
    assign last_idx  = r_count - CW'(1);
    assign last_step = (r_step == IW'(last_idx));

    // per-cell order compare against the incoming score
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_score[i] >= i_queue.job.score);
        end
        prev_ge[0] = 1'b1;
        for (int i = 1; i < CAPACITY; i++) begin
            prev_ge[i] = ge[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_key[i]   = r_key[i];
            n_score[i] = r_score[i];
        end
        n_count  = r_count;
        n_state  = r_state;
        n_step   = r_step;
        n_search = r_search;
        n_hit    = r_hit;
        n_tkey   = r_tkey;
        n_valid  = 1'b0;
        n_res    = '0;
        o_pop    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_queue.valid) begin
                    o_pop = 1'b1;
                    if (i_queue.job.is_insert) begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (!ge[i]) begin
                                if (prev_ge[i]) begin
                                    n_key[i]   = job_key;
                                    n_score[i] = i_queue.job.score;
                                end else begin
                                    n_key[i]   = r_key[(i > 0) ? i - 1 : 0];
                                    n_score[i] = r_score[(i > 0) ? i - 1 : 0];
                                end
                            end
                        end
                        if (!ge[CAPACITY-1] && (r_count != CW'(CAPACITY))) begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_valid    = 1'b1;
                        n_res.last = 1'b1;
                    end else begin
                        n_state  = ST_SCAN;
                        n_step   = '0;
                        n_hit    = 1'b0;
                        n_search = i_queue.job.is_search;
                        n_tkey   = job_key;
                    end
                end
            end
            ST_SCAN: begin
                // rotate the held entries by one, head wraps to the last valid cell
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (CW'(i) == last_idx) begin
                        n_key[i]   = r_key[0];
                        n_score[i] = r_score[0];
                    end else begin
                        n_key[i]   = r_key[i+1];
                        n_score[i] = r_score[i+1];
                    end
                end
                if (r_count == CW'(CAPACITY)) begin
                    n_key[CAPACITY-1]   = r_key[0];
                    n_score[CAPACITY-1] = r_score[0];
                end
                n_step = r_step + IW'(1);
                if (last_step) begin
                    n_state = ST_IDLE;
                end
                if (!r_search) begin
                    n_valid           = 1'b1;
                    n_res.found       = 1'b1;
                    n_res.entry_key   = 32'(r_key[0]);
                    n_res.entry_score = r_score[0];
                    n_res.last        = last_step;
                end else if (!r_hit && (r_key[0] == r_tkey)) begin
                    n_hit             = 1'b1;
                    n_valid           = 1'b1;
                    n_res.found       = 1'b1;
                    n_res.entry_key   = 32'(r_key[0]);
                    n_res.entry_score = r_score[0];
                    n_res.last        = 1'b1;
                end else if (!r_hit && last_step) begin
                    n_valid    = 1'b1;
                    n_res.last = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_state <= n_state;
            r_valid <= n_valid;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_key[i]   <= n_key[i];
            r_score[i] <= n_score[i];
        end
        r_step   <= n_step;
        r_search <= n_search;
        r_tkey   <= n_tkey;
        r_res    <= n_res;
    end

    assign o_valid           = r_valid;
    assign o_result          = r_res;
    assign o_status.scanning = (r_state == ST_SCAN);
    assign o_status.count_ok = (r_count <= CW'(CAPACITY));

endmodule

// ----- design/top_k_sorted_score_table_unit.sv -----
`timescale 1ns / 1ps

// top-k score table: keeps up to CAPACITY (key, score) entries, highest score first
// command channel: i_cmd is taken at a clock edge with start high and busy low
//   opcode insert places the entry after equal scores and drops the lowest when full
//   opcode search returns the first entry with that key, or one not-found word
//   opcode list returns every entry top down, last set on the final word
//   opcode 3 is taken and dropped without a result
// result channel: o_valid marks each o_result word for one cycle, no back-pressure
// a two-word queue separates command intake from the table engine
// insert: handled in the idle state, no result
// search or list on n entries: a dispatch from the idle state, then a table walk over the n entries
// list words come back to back
// empty table search or list: one not-found word with last set
// the table walk rotates the entries by one per cycle
// busy is high only while the queue holds two commands
// reset empties the table and the queue and clears o_valid
module top_k_sorted_score_table_unit #(
    parameter int CAPACITY = tkst_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = tkst_pkg::KEY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tkst_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output tkst_pkg::t_result o_result
);

    tkst_pkg::t_queue_out queue;
    tkst_pkg::t_status    status;
    logic                 pop;

    tkst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_queue (queue),
        .i_pop   (pop)
    );

    tkst_back #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_queue  (queue),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_status (status)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count_ok)
        else $error("entry count above capacity");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.found) |-> o_result.last)
        else $error("not-found word without last");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.found) |->
        (o_result.entry_key == '0 && o_result.entry_score == '0))
        else $error("not-found word carries data");

    a_list_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> o_valid)
        else $error("gap inside a list");

    a_scan_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> status.scanning)
        else $error("open list word outside a table walk");

endmodule
